@@ rtl/core/smu_pkg.sv @@
// Shared types, constants and helpers for the substring matcher.
`default_nettype none

package smu_pkg;

    localparam int ADDR_W        = 5;
    localparam int DATA_W        = 64;
    localparam int INDEX_W       = 16;
    localparam int LEN_W         = 5;
    localparam int PATTERN_BYTES = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_PATTERN_LENGTH = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic last;
        logic hit;
        logic ovf;
    } byte_flags_t;

    // pattern byte k; bytes past the two pattern registers read as zero
    function automatic logic [7:0] pattern_byte(
        input logic [8*PATTERN_BYTES-1:0] pat,
        input logic [LEN_W-1:0]           k
    );
        logic [7:0] b;
        b = '0;
        if (!k[LEN_W-1]) begin
            b = pat[{k[LEN_W-2:0], 3'b000} +: 8];
        end
        return b;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/smu_front.sv @@
// Front end: takes text bytes, keeps the window and position, classifies each byte.
`default_nettype none

module smu_front #(
    parameter int PATTERN_MAX   = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic [8*smu_pkg::PATTERN_BYTES-1:0]      pattern,
    input  logic [smu_pkg::LEN_W-1:0]                pattern_length,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [7:0]                               text_byte,
    input  logic                                     last_byte,
    input  logic                                     q_full,
    output logic                                     push,
    output smu_pkg::byte_flags_t                     flags,
    output logic [POSITION_BITS-1:0]                 start
);

    localparam int FILL_W = $clog2(PATTERN_MAX + 1);
    localparam int SUM_W  = POSITION_BITS + 1;

    logic [7:0]                 win_reg   [PATTERN_MAX];
    logic [7:0]                 win_shift [PATTERN_MAX];
    logic [FILL_W-1:0]          fill_reg;
    logic [FILL_W-1:0]          fill_inc;
    logic [POSITION_BITS-1:0]   count_reg;
    logic [POSITION_BITS-1:0]   count_next;
    logic [FILL_W-1:0]          fill_next;
    logic [smu_pkg::LEN_W-1:0]  len;
    logic                       bytes_equal;
    logic                       hit;
    logic                       at_max;
    logic [SUM_W-1:0]           pos_end;
    logic [SUM_W-1:0]           len_ext;

    // active length: zero reads as one, clamp to window depth
    always_comb
    begin
        if (pattern_length == '0)
        begin
            len = smu_pkg::LEN_W'(1);
        end
        else if (32'(pattern_length) > PATTERN_MAX)
        begin
            len = smu_pkg::LEN_W'(PATTERN_MAX);
        end
        else
        begin
            len = pattern_length;
        end
    end

    always_comb
    begin
        win_shift[0] = text_byte;
        for (int i = 1; i < PATTERN_MAX; i++)
        begin
            win_shift[i] = win_reg[i-1];
        end
    end

    assign fill_inc = (32'(fill_reg) < PATTERN_MAX) ? fill_reg + FILL_W'(1) : fill_reg;

    // newest byte sits at index 0, so pattern byte k lines up with index len-1-k
    always_comb
    begin
        bytes_equal = 1'b1;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            if (32'(len) > j)
            begin
                if (win_shift[j] != smu_pkg::pattern_byte(pattern,
                        smu_pkg::LEN_W'(32'(len) - 1 - j)))
                begin
                    bytes_equal = 1'b0;
                end
            end
        end
    end

    assign hit     = bytes_equal && (32'(fill_inc) >= 32'(len));
    assign at_max  = &count_reg;
    assign pos_end = SUM_W'(count_reg) + SUM_W'(1);
    assign len_ext = SUM_W'(len);
    assign start   = (pos_end >= len_ext) ? POSITION_BITS'(pos_end - len_ext) : '0;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    assign flags = '{last: last_byte, hit: hit, ovf: at_max};

    always_comb
    begin
        fill_next  = fill_reg;
        count_next = count_reg;
        if (push)
        begin
            if (last_byte)
            begin
                fill_next  = '0;
                count_next = '0;
            end
            else
            begin
                fill_next  = fill_inc;
                count_next = at_max ? count_reg : count_reg + POSITION_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            fill_reg  <= fill_next;
            count_reg <= count_next;
        end
    end

    // window bytes past the fill count can be compared, but a hit needs the fill to reach the length
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                win_reg[i] <= win_shift[i];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/smu_queue.sv @@
// Short FIFO between the front end and the match tracker.
`default_nettype none

module smu_queue #(
    parameter int WIDTH = 19
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = smu_pkg::QUEUE_AW;

    logic [WIDTH-1:0] mem [smu_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_next;
    logic [AW:0]      count_next;

    assign full  = (count_reg == (AW+1)'(smu_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (AW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/smu_back.sv @@
// Back end: folds classified bytes into match records and holds the result register.
`default_nettype none

module smu_back #(
    parameter int POSITION_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  smu_pkg::byte_flags_t          q_flags,
    input  logic [POSITION_BITS-1:0]      q_start,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          match_found,
    output logic [smu_pkg::INDEX_W-1:0]   first_index,
    output logic [smu_pkg::INDEX_W-1:0]   final_index,
    output logic                          starts_with,
    output logic                          ends_with,
    output logic                          length_overflow
);

    localparam int IW = smu_pkg::INDEX_W;

    logic                     seen_reg;
    logic [POSITION_BITS-1:0] first_reg;
    logic [POSITION_BITS-1:0] latest_reg;
    logic                     prefix_reg;
    logic                     ovf_reg;

    logic                     out_valid_reg;
    logic                     match_found_reg;
    logic [IW-1:0]            first_index_reg;
    logic [IW-1:0]            final_index_reg;
    logic                     starts_with_reg;
    logic                     ends_with_reg;
    logic                     length_overflow_reg;

    logic                     out_free;
    logic                     emit;
    logic                     ovf_now;
    logic                     seen_now;
    logic [POSITION_BITS-1:0] first_now;
    logic [POSITION_BITS-1:0] latest_now;
    logic                     prefix_now;

    assign out_free = !out_valid_reg || out_ready;
    assign pop      = !q_empty && (!q_flags.last || out_free);
    assign emit     = pop && q_flags.last;

    always_comb
    begin
        ovf_now    = ovf_reg | q_flags.ovf;
        seen_now   = seen_reg | q_flags.hit;
        first_now  = (q_flags.hit && !seen_reg) ? q_start : first_reg;
        latest_now = q_flags.hit ? q_start : latest_reg;
        prefix_now = prefix_reg | (q_flags.hit && (q_start == '0) && !ovf_now);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            first_reg     <= '0;
            latest_reg    <= '0;
            prefix_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (q_flags.last)
                begin
                    seen_reg   <= 1'b0;
                    first_reg  <= '0;
                    latest_reg <= '0;
                    prefix_reg <= 1'b0;
                    ovf_reg    <= 1'b0;
                end
                else
                begin
                    seen_reg   <= seen_now;
                    first_reg  <= first_now;
                    latest_reg <= latest_now;
                    prefix_reg <= prefix_now;
                    ovf_reg    <= ovf_now;
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            match_found_reg     <= seen_now;
            first_index_reg     <= seen_now ? IW'(first_now) : '0;
            final_index_reg     <= seen_now ? IW'(latest_now) : '0;
            starts_with_reg     <= prefix_now;
            ends_with_reg       <= q_flags.hit;
            length_overflow_reg <= ovf_now;
        end
    end

    assign out_valid       = out_valid_reg;
    assign match_found     = match_found_reg;
    assign first_index     = first_index_reg;
    assign final_index     = final_index_reg;
    assign starts_with     = starts_with_reg;
    assign ends_with       = ends_with_reg;
    assign length_overflow = length_overflow_reg;

    a_ends_implies_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ends_with_reg) |-> match_found_reg)
        else $error("ends_with set without a match");

    a_starts_implies_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && starts_with_reg) |-> (match_found_reg && first_index_reg == '0))
        else $error("starts_with set but first occurrence not at zero");

    a_no_match_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !match_found_reg)
            |-> (first_index_reg == '0 && final_index_reg == '0 && !starts_with_reg))
        else $error("indices or prefix flag set without a match");

    a_record_cleared_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (!seen_reg && !prefix_reg && !ovf_reg))
        else $error("match records not cleared after final byte");

endmodule

`default_nettype wire

@@ rtl/core/substring_matcher_unit.sv @@
// Top level of the streaming substring matcher with its APB register file.
// A result is registered once the byte marked last has left the queue; bytes queued ahead are taken first.
// Throughput: one text byte per cycle while the queue is not full; the window compare completes in the cycle
// the byte is taken, and a 4-entry queue feeds the match tracker.
// Reset clears control and match state but not the window or result fields; pattern registers reset to
// pattern_low = 0, pattern_high = 0, pattern_length = 1.
`default_nettype none

module substring_matcher_unit #(
    parameter int PATTERN_MAX   = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [smu_pkg::ADDR_W-1:0]     paddr,
    input  logic [smu_pkg::DATA_W-1:0]     pwdata,
    output logic [smu_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     text_byte,
    input  logic                           last_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           match_found,
    output logic [smu_pkg::INDEX_W-1:0]    first_index,
    output logic [smu_pkg::INDEX_W-1:0]    final_index,
    output logic                           starts_with,
    output logic                           ends_with,
    output logic                           length_overflow
);

    localparam int QW = $bits(smu_pkg::byte_flags_t) + POSITION_BITS;

    logic [smu_pkg::DATA_W-1:0] pattern_low_reg;
    logic [smu_pkg::DATA_W-1:0] pattern_high_reg;
    logic [smu_pkg::LEN_W-1:0]  pattern_length_reg;
    logic                       cfg_write;
    smu_pkg::reg_index_t        reg_sel;

    logic                       push;
    logic                       pop;
    logic                       q_full;
    logic                       q_empty;
    smu_pkg::byte_flags_t       f_flags;
    logic [POSITION_BITS-1:0]   f_start;
    smu_pkg::byte_flags_t       q_flags;
    logic [POSITION_BITS-1:0]   q_start;
    logic [QW-1:0]              q_wdata;
    logic [QW-1:0]              q_rdata;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = smu_pkg::reg_index_t'(paddr[smu_pkg::ADDR_W-1:3]);

    always_comb
    begin
        unique case (reg_sel)
            smu_pkg::REG_PATTERN_LOW:    prdata = pattern_low_reg;
            smu_pkg::REG_PATTERN_HIGH:   prdata = pattern_high_reg;
            smu_pkg::REG_PATTERN_LENGTH: prdata = smu_pkg::DATA_W'(pattern_length_reg);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= smu_pkg::LEN_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                smu_pkg::REG_PATTERN_LOW:    pattern_low_reg    <= pwdata;
                smu_pkg::REG_PATTERN_HIGH:   pattern_high_reg   <= pwdata;
                smu_pkg::REG_PATTERN_LENGTH: pattern_length_reg <= pwdata[smu_pkg::LEN_W-1:0];
                default:                     pattern_length_reg <= pattern_length_reg;
            endcase
        end
    end

    smu_front #(
        .PATTERN_MAX   (PATTERN_MAX),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .pattern        ({pattern_high_reg, pattern_low_reg}),
        .pattern_length (pattern_length_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .text_byte      (text_byte),
        .last_byte      (last_byte),
        .q_full         (q_full),
        .push           (push),
        .flags          (f_flags),
        .start          (f_start)
    );

    assign q_wdata = {f_flags, f_start};

    smu_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign q_flags = smu_pkg::byte_flags_t'(q_rdata[QW-1:POSITION_BITS]);
    assign q_start = q_rdata[POSITION_BITS-1:0];

    smu_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_flags         (q_flags),
        .q_start         (q_start),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .match_found     (match_found),
        .first_index     (first_index),
        .final_index     (final_index),
        .starts_with     (starts_with),
        .ends_with       (ends_with),
        .length_overflow (length_overflow)
    );

endmodule

`default_nettype wire
